// ===== src/rdp_pkg.sv =====
// Shared constants and codes of the random draw pool.
package rdp_pkg;

	localparam int POOL_DEPTH = 4096;
	localparam int ADDR_W     = $clog2(POOL_DEPTH);
	localparam int CNT_W      = 13;
	localparam int BALL_W     = 31;
	localparam int RND_W      = 64;
	localparam int RND_CNT_W  = $clog2(RND_W);
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_DRAW   = 1'b1
	} kind_t;

endpackage

// ===== src/rdp_if.sv =====
// Channel interfaces of the random draw pool: items, results and configuration.
interface rdp_item_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [rdp_pkg::BALL_W-1:0] ball_value;
	logic [rdp_pkg::RND_W-1:0]  random_value;

	modport source (output valid, kind, ball_value, random_value, input ready);
	modport sink   (input valid, kind, ball_value, random_value, output ready);
endinterface

interface rdp_result_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [rdp_pkg::BALL_W-1:0] drawn_ball;
	logic                       pool_empty;
	logic [rdp_pkg::CNT_W-1:0]  ball_count;

	modport source (output valid, status, drawn_ball, pool_empty, ball_count, input ready);
	modport sink   (input valid, status, drawn_ball, pool_empty, ball_count, output ready);
endinterface

interface rdp_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [rdp_pkg::CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== src/rdp_mod_serial.sv =====
// Bit-serial restoring modulo of the random value by the ball count.
module rdp_mod_serial (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rdp_pkg::RND_W-1:0]  dividend,
	input  logic [rdp_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [rdp_pkg::CNT_W-1:0]  remainder
);
	import rdp_pkg::*;

	typedef enum logic {
		MS_IDLE,
		MS_RUN
	} mod_state_t;

	mod_state_t           state_q;
	logic [RND_W-1:0]     div_q;
	logic [CNT_W-1:0]     rem_q;
	logic [RND_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       diff;

	// shift in the next dividend bit, subtract the divisor when it fits
	assign trial = {rem_q, div_q[RND_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MS_IDLE: begin
					if (start) begin
						div_q   <= dividend;
						rem_q   <= '0;
						cnt_q   <= RND_CNT_W'(RND_W - 1);
						state_q <= MS_RUN;
					end
				end
				MS_RUN: begin
					if (trial >= {1'b0, divisor}) begin
						rem_q <= diff[CNT_W-1:0];
					end else begin
						rem_q <= trial[CNT_W-1:0];
					end
					div_q <= {div_q[RND_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= MS_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== src/random_draw_pool_core.sv =====
// Top level of the random draw pool: control, ball store and result register.
//
//  channel    | dir | transfer moves
//  -----------+-----+----------------------------------------------
//  item_in    | in  | kind, ball_value, random_value
//  result_out | out | status, drawn_ball, pool_empty, ball_count
//  cfg        | in  | capacity (no index, always ready)
//
// One item at a time. An insert, or a draw from an empty pool, writes its result
// from ST_EXEC. A draw from a non-empty pool passes through ST_MOD, the bit-serial
// modulo of the 64-bit random value (one bit per cycle), ST_READ, the registered
// read of the ball store, and ST_FIN. A stalled result holds in the output
// register; the next item is taken then and waits there to finish. Reset
// clears the count and loads the capacity with 4096; the store is not cleared.
module random_draw_pool_core (
	input  logic                 clk,
	input  logic                 arst_n,
	rdp_item_if.sink             item_in,
	rdp_result_if.source         result_out,
	rdp_cfg_if.sink              cfg
);
	import rdp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MOD,
		ST_READ,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic              kind_q;
	logic [BALL_W-1:0] ball_q;
	logic [RND_W-1:0]  rnd_q;

	logic              res_valid_q;
	status_t           res_status_q;
	logic [BALL_W-1:0] res_ball_q;
	logic              res_empty_q;
	logic [CNT_W-1:0]  res_count_q;

	logic [BALL_W-1:0] ball_store [POOL_DEPTH];
	logic [BALL_W-1:0] slot_data_q;
	logic [BALL_W-1:0] last_data_q;

	logic              out_free;
	logic              full;
	logic [CNT_W-1:0]  count_dec;
	logic              mod_start;
	logic              mod_done;
	logic [CNT_W-1:0]  mod_rem;
	logic [ADDR_W-1:0] slot_addr;
	logic [ADDR_W-1:0] last_addr;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [BALL_W-1:0] wr_data;

	// the output register can take a new result when empty or draining now
	assign out_free  = !res_valid_q || result_out.ready;
	// capacity above the store depth saturates at the depth
	assign full      = (count_q >= cap_q) || (count_q >= POOL_DEPTH);
	assign count_dec = count_q - 1'b1;
	assign slot_addr = mod_rem[ADDR_W-1:0];
	assign last_addr = count_dec[ADDR_W-1:0];

	assign item_in.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;

	// a non-empty draw starts the modulo unit; the count is stable until ST_FIN
	assign mod_start = (state_q == ST_EXEC) && (kind_q == KIND_DRAW) && (count_q != '0);

	rdp_mod_serial u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (rnd_q),
		.divisor   (count_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// store port: an insert appends at the count, a draw moves the last ball
	// into the vacated slot (harmless when the slot is the last one)
	always_comb begin
		rd_en   = (state_q == ST_READ);
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = ball_q;
		if ((state_q == ST_EXEC) && (kind_q == KIND_INSERT) && !full && out_free) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_FIN) && out_free) begin
			wr_en   = 1'b1;
			wr_addr = slot_addr;
			wr_data = last_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			slot_data_q <= ball_store[slot_addr];
			last_data_q <= ball_store[last_addr];
		end
		if (wr_en) begin
			ball_store[wr_addr] <= wr_data;
		end
	end

	// item capture: payload only, no reset needed
	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			kind_q <= item_in.kind;
			ball_q <= item_in.ball_value;
			rnd_q  <= item_in.random_value;
		end
	end

	// control state, count, capacity and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end
			// drop the result once the sink takes it
			if (res_valid_q && result_out.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_in.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (kind_q == KIND_DRAW && count_q != '0) begin
						state_q <= ST_MOD;
					end else if (out_free) begin
						// insert, or draw from an empty pool: finish here
						res_valid_q <= 1'b1;
						res_ball_q  <= '0;
						if (kind_q == KIND_DRAW) begin
							res_status_q <= STATUS_EMPTY;
							res_empty_q  <= 1'b1;
							res_count_q  <= count_q;
						end else if (full) begin
							res_status_q <= STATUS_FULL;
							res_empty_q  <= (count_q == '0);
							res_count_q  <= count_q;
						end else begin
							res_status_q <= STATUS_OK;
							res_empty_q  <= 1'b0;
							res_count_q  <= count_q + 1'b1;
							count_q      <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_status_q <= STATUS_OK;
						res_ball_q   <= slot_data_q;
						res_empty_q  <= (count_dec == '0);
						res_count_q  <= count_dec;
						count_q      <= count_dec;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_out.valid      = res_valid_q;
	assign result_out.status     = res_status_q;
	assign result_out.drawn_ball = res_ball_q;
	assign result_out.pool_empty = res_empty_q;
	assign result_out.ball_count = res_count_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the random draw pool: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module testbench;
	import rdp_pkg::*;

	// Largest random value the bench puts in the item field.
	localparam logic [RND_W-1:0] RND_MAX     = 64'd9999999999999999999;
	localparam int               IDLE_PCT    = 37;
	localparam int               HOLD_CYCLES = 400;
	localparam int               CYCLE_LIMIT = 1000000;
	localparam int               TAIL_CYCLES = 100;
	localparam int               SHOW_LIMIT  = 10;

	typedef struct {
		kind_t             kind;
		logic [BALL_W-1:0] ball_value;
		logic [RND_W-1:0]  random_value;
	} draw_item_t;

	typedef struct {
		status_t           status;
		logic [BALL_W-1:0] drawn_ball;
		logic              pool_empty;
		logic [CNT_W-1:0]  ball_count;
	} pool_result_t;

	logic clk;
	logic arst_n;

	rdp_item_if   item_ch ();
	rdp_result_if res_ch ();
	rdp_cfg_if    cfg_ch ();

	random_draw_pool_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (res_ch),
		.cfg        (cfg_ch)
	);

	// Items waiting to be offered, and pool results predicted but not yet seen.
	draw_item_t   draw_items_q [$];
	pool_result_t pool_results_q [$];

	// Private copy of the pool: ball slots, occupancy and capacity register.
	logic [BALL_W-1:0] ball_slots [POOL_DEPTH];
	int unsigned       held_balls;
	logic [CNT_W-1:0]  pool_capacity;

	draw_item_t offered_item;
	int         accepted_items;
	int         hold_left;
	int         holds_done;
	int         cycle_count;
	int         mismatches;
	int         results_seen;
	int         n_inserts;
	int         n_draws;
	int         n_full;
	int         n_empty;
	int         n_settings;

	// Both sides stop idling over one stretch of the run, counted in accepted items.
	wire calm = (accepted_items >= 600) && (accepted_items < 850);

	// Clock, reset, and known levels on every input from time zero.
	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.kind         = KIND_INSERT;
		item_ch.ball_value   = '0;
		item_ch.random_value = '0;
		res_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.data          = '0;
		fork
			forever #10 clk = ~clk;
			begin
				repeat (5) @(posedge clk);
				// Release away from the rising edge so the release never races the clock.
				@(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// Advance the private pool by one accepted item and queue the result it must give.
	task automatic advance_pool(input draw_item_t it);
		pool_result_t r;
		int unsigned  slot;
		int unsigned  limit;
		r.status     = STATUS_OK;
		r.drawn_ball = '0;
		// Capacity beyond the store depth saturates at the depth.
		limit = (pool_capacity > POOL_DEPTH) ? POOL_DEPTH : pool_capacity;
		if (it.kind == KIND_INSERT) begin
			n_inserts++;
			if (held_balls >= limit) begin
				// Full pool: nothing is stored, the count holds.
				r.status = STATUS_FULL;
				n_full++;
			end else begin
				ball_slots[held_balls] = it.ball_value;
				held_balls++;
			end
		end else begin
			n_draws++;
			if (held_balls == 0) begin
				// Empty pool: report it, drawn ball stays zero.
				r.status = STATUS_EMPTY;
				n_empty++;
			end else begin
				// Pick the slot, then move the last ball into the hole it leaves.
				slot         = int'(it.random_value % 64'(held_balls));
				r.drawn_ball = ball_slots[slot];
				held_balls--;
				ball_slots[slot] = ball_slots[held_balls];
			end
		end
		r.pool_empty = (held_balls == 0);
		r.ball_count = CNT_W'(held_balls);
		pool_results_q.push_back(r);
	endtask

	// Item driver: present the next queued item, hold it until the transfer.
	always @(posedge clk) begin : item_driver
		draw_item_t nxt;
		if (!arst_n) begin
			item_ch.valid  <= 1'b0;
			accepted_items <= 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				advance_pool(offered_item);
				accepted_items <= accepted_items + 1;
			end
			// A new item may go out only once the current one has been taken.
			if (!item_ch.valid || item_ch.ready) begin
				if (draw_items_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					nxt                  = draw_items_q.pop_front();
					offered_item         = nxt;
					item_ch.valid        <= 1'b1;
					item_ch.kind         <= nxt.kind;
					item_ch.ball_value   <= nxt.ball_value;
					item_ch.random_value <= nxt.random_value;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off: twice in the run the result side stops taking transfers
	// for a long stretch while items keep coming, so the block backs up into its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && accepted_items >= 150) ||
		             (holds_done == 1 && accepted_items >= 1300)) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// Result monitor: compare each transfer with the oldest prediction, then pick
	// the next ready level.
	always @(posedge clk) begin : result_monitor
		pool_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (pool_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("ERROR: result with nothing predicted: status %0d ball %0d count %0d",
							res_ch.status, res_ch.drawn_ball, res_ch.ball_count);
				end else begin
					want = pool_results_q.pop_front();
					if (res_ch.status !== want.status || res_ch.drawn_ball !== want.drawn_ball ||
					    res_ch.pool_empty !== want.pool_empty ||
					    res_ch.ball_count !== want.ball_count) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT)
							$display("ERROR: result %0d: want status %0d ball %0d empty %0d count %0d, got status %0d ball %0d empty %0d count %0d",
								results_seen, want.status, want.drawn_ball, want.pool_empty,
								want.ball_count, res_ch.status, res_ch.drawn_ball,
								res_ch.pool_empty, res_ch.ball_count);
					end
				end
			end
			res_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				pool_results_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic queue_item(input kind_t kind, input logic [BALL_W-1:0] ball,
	                          input logic [RND_W-1:0] rnd);
		draw_item_t it;
		it.kind         = kind;
		it.ball_value   = ball;
		it.random_value = rnd;
		draw_items_q.push_back(it);
	endtask

	// Random items with a given share of inserts; fields lean toward their extremes.
	task automatic queue_random_phase(input int count, input int insert_pct);
		kind_t             kind;
		logic [BALL_W-1:0] ball;
		logic [RND_W-1:0]  rnd;
		for (int i = 0; i < count; i++) begin
			kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DRAW;
			case ($urandom_range(9))
				0:       ball = '0;
				1:       ball = '1;
				default: ball = BALL_W'($urandom);
			endcase
			case ($urandom_range(7))
				0:       rnd = '0;
				1:       rnd = RND_MAX;
				2:       rnd = RND_W'($urandom_range(15));
				default: begin
					rnd = {$urandom, $urandom};
					// Fold the part above the field's range back into it.
					if (rnd > RND_MAX)
						rnd = rnd - RND_MAX - 1;
				end
			endcase
			queue_item(kind, ball, rnd);
		end
	endtask

	// Wait until every queued item has gone out and every prediction has been met.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (draw_items_q.size() != 0 || item_ch.valid || pool_results_q.size() != 0);
	endtask

	// Write the capacity register with the block idle.
	task automatic set_capacity(input logic [CNT_W-1:0] cap);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_ch.data  <= cap;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		pool_capacity = cap;
		cfg_ch.valid  <= 1'b0;
		n_settings++;
		@(negedge clk);
	endtask

	// Sequencer: directed checks first, then random phases over several capacities.
	initial begin : sequencer
		held_balls    = 0;
		pool_capacity = CAP_RESET;
		cycle_count   = 0;
		mismatches    = 0;
		results_seen  = 0;
		n_inserts     = 0;
		n_draws       = 0;
		n_full        = 0;
		n_empty       = 0;
		n_settings    = 0;
		@(posedge arst_n);

		// Smallest capacity: empty draw, field extremes, full insert, draining to empty.
		set_capacity(CNT_W'(2));
		queue_item(KIND_DRAW,   '0,              '0);
		queue_item(KIND_INSERT, '0,              '0);
		queue_item(KIND_INSERT, '1,              RND_MAX);
		queue_item(KIND_INSERT, 31'h2AAA_AAAA,   '0);
		queue_item(KIND_DRAW,   '0,              RND_MAX);
		queue_item(KIND_DRAW,   '1,              '0);
		queue_item(KIND_DRAW,   '0,              64'd5);
		queue_item(KIND_INSERT, 31'h5555_5555,   '0);
		queue_item(KIND_INSERT, 31'h2AAA_AAAA,   '0);

		// Raise the capacity and fill the pool, then hit the full limit.
		set_capacity(CNT_W'(5));
		queue_item(KIND_INSERT, 31'd1,           '0);
		queue_item(KIND_INSERT, 31'd2,           '0);
		queue_item(KIND_INSERT, 31'd3,           '0);
		queue_item(KIND_INSERT, 31'd4,           '0);

		// Lower the capacity under the count: inserts refuse until draws catch up.
		set_capacity(CNT_W'(3));
		queue_item(KIND_INSERT, 31'd5,           '0);
		queue_item(KIND_DRAW,   '0,              64'h8000_0000_0000_0001);
		queue_item(KIND_DRAW,   '0,              64'd3);
		queue_item(KIND_INSERT, 31'd6,           '0);
		queue_item(KIND_DRAW,   '0,              64'd1);
		queue_item(KIND_INSERT, 31'd7,           '0);
		queue_item(KIND_INSERT, 31'd8,           '0);

		// Random phases.
		set_capacity(CNT_W'(2));
		queue_random_phase(200, 50);
		set_capacity(CNT_W'(17));
		queue_random_phase(250, 55);
		set_capacity(CAP_RESET);
		queue_random_phase(350, 70);
		set_capacity(CNT_W'(64));
		queue_random_phase(250, 35);
		set_capacity(CNT_W'($urandom_range(4096, 2)));
		queue_random_phase(250, 50);
		set_capacity(CNT_W'(10));
		queue_random_phase(250, 40);
		set_capacity(CAP_RESET);
		queue_random_phase(300, 50);

		// Let everything finish, then watch a little longer for stray results.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d inserts (%0d refused full) and %0d draws (%0d on empty pool)",
			n_inserts, n_full, n_draws, n_empty);
		$display("over %0d capacity writes; %0d results checked, %0d mismatches",
			n_settings, results_seen, mismatches);
		if (mismatches == 0 && pool_results_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/rdp_pkg.sv
src/rdp_if.sv
src/rdp_mod_serial.sv
src/random_draw_pool_core.sv
test/testbench.sv
